// ===== hw/rtl/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg: shared types and constants for the contiguous block allocator
// Holds the sequencer state type, the scan-unit control group and the
// fixed field widths of the request and result streams.
// ----------------------------------------------------------------------------
package cba_pkg;

    // Fixed widths of the stream fields.
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned OWNER_W = 10;
    localparam int unsigned BASE_W  = 10;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_DECIDE,
        ST_WRITE,
        ST_DONE
    } cba_state_t;

    // Control group from the sequencer to the run scanner.
    typedef struct packed {
        logic start;  // clear the run tracker for a new request
        logic step;   // one cell's read data is presented
        logic last;   // the presented cell is the last one in memory
        logic best;   // best fit when set, first fit otherwise
    } scan_ctl_t;

endpackage

// ===== hw/rtl/cba_mem.sv =====
// ----------------------------------------------------------------------------
// cba_mem: cell owner memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cba_mem #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned DATA_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/cba_scan.sv =====
// ----------------------------------------------------------------------------
// cba_scan: free-run tracker
// Consumes one cell per step, measures each maximal free run and keeps the
// run that first fit or best fit selects.
// ----------------------------------------------------------------------------
module cba_scan
    import cba_pkg::*;
#(
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned CNT_W  = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  scan_ctl_t         ctl,
    input  logic              cell_free,
    input  logic [ADDR_W-1:0] cell_addr,
    input  logic [SIZE_W-1:0] req_size,
    output logic              found,
    output logic [ADDR_W-1:0] pick_base
);

    logic [CNT_W-1:0]  run_len_reg,   run_len_next;
    logic [ADDR_W-1:0] run_start_reg, run_start_next;
    logic              found_reg,     found_next;
    logic [ADDR_W-1:0] pick_base_reg, pick_base_next;
    logic [CNT_W-1:0]  pick_len_reg,  pick_len_next;

    logic [CNT_W-1:0]  cur_len;
    logic [ADDR_W-1:0] cur_start;
    logic              run_close;
    logic              fits;
    logic              take;

    always_comb begin
        cur_len   = cell_free ? run_len_reg + CNT_W'(1) : run_len_reg;
        cur_start = (cell_free && run_len_reg == '0) ? cell_addr : run_start_reg;
        // A run ends at an occupied cell after free ones, or at the memory end.
        run_close = ctl.step && ((!cell_free && run_len_reg != '0) ||
                                 (cell_free && ctl.last));
        fits      = 32'(cur_len) >= 32'(req_size);
        take      = run_close && fits &&
                    (!found_reg || (ctl.best && cur_len < pick_len_reg));

        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        found_next     = found_reg;
        pick_base_next = pick_base_reg;
        pick_len_next  = pick_len_reg;

        if (ctl.start) begin
            run_len_next = '0;
            found_next   = 1'b0;
        end else if (ctl.step) begin
            run_len_next   = (cell_free && !ctl.last) ? cur_len : '0;
            run_start_next = cur_start;
            if (take) begin
                found_next     = 1'b1;
                pick_base_next = cur_start;
                pick_len_next  = cur_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg <= '0;
            found_reg   <= 1'b0;
        end else begin
            run_len_reg <= run_len_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_start_reg <= run_start_next;
        pick_base_reg <= pick_base_next;
        pick_len_reg  <= pick_len_next;
    end

    assign found     = found_reg;
    assign pick_base = pick_base_reg;

endmodule

// ===== hw/rtl/contiguous_block_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_block_allocator: first-fit / best-fit contiguous cell allocator
// A granted request scans every cell, then writes request_size cells before its result
// is loaded; a scanned request that finds no run skips the write, and a refused
// one (zero size, zero owner, larger than memory) goes straight to its result. With
// the result stream ready, s_tready returns in the cycle after the result is loaded,
// so no new request is taken before the last one is done; the single read port of
// the cell memory, walked cell by cell, sets the scan time. After reset a clearing
// pass frees every cell with s_tready low. fit_mode resets to first fit.
// ----------------------------------------------------------------------------
module contiguous_block_allocator
    import cba_pkg::*;
#(
    parameter int unsigned MEM_CELLS  = 1024,
    parameter int unsigned OWNER_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: bit 0 is fit_mode (0 first fit, 1 best fit).
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,

    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [10:0] request_size, [20:11] owner_id, rest zero

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] base_address, rest zero
    output logic        m_tuser    // granted
);

    // Address width covers the cells; count width also holds MEM_CELLS itself.
    localparam int unsigned ADDR_W = $clog2(MEM_CELLS);
    localparam int unsigned CNT_W  = $clog2(MEM_CELLS + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_CELLS - 1);

    cba_state_t state_reg, state_next;

    logic                  fit_mode_reg;
    logic [ADDR_W-1:0]     addr_reg,     addr_next;
    logic [CNT_W-1:0]      cnt_reg,      cnt_next;
    logic [SIZE_W-1:0]     req_size_reg, req_size_next;
    logic [OWNER_BITS-1:0] owner_reg,    owner_next;

    // Alignment stage for the registered memory read.
    logic                  pipe_vld_reg,  pipe_vld_next;
    logic [ADDR_W-1:0]     pipe_addr_reg;
    logic                  pipe_last_reg;

    logic                  grant_reg,    grant_next;
    logic                  m_tvalid_reg;
    logic                  m_grant_reg;
    logic [BASE_W-1:0]     m_base_reg;

    // Decoded request fields.
    logic [SIZE_W-1:0]     in_size;
    logic [15:0]           in_owner_wide;
    logic [OWNER_BITS-1:0] in_owner;
    logic                  in_ok;
    logic                  accept;

    // Sequencer outputs.
    logic                  mem_wr_en;
    logic [OWNER_BITS-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [OWNER_BITS-1:0] mem_rd_data;
    logic                  out_load;
    scan_ctl_t             scan_ctl;
    logic                  scan_found;
    logic [ADDR_W-1:0]     scan_base;
    logic [31:0]           base_wide;

    assign in_size       = s_tdata[SIZE_W-1:0];
    assign in_owner_wide = {6'd0, s_tdata[SIZE_W+OWNER_W-1:SIZE_W]};
    assign in_owner      = in_owner_wide[OWNER_BITS-1:0];
    // Requests that can never be granted skip the scan entirely.
    assign in_ok         = (in_size != '0) && (in_owner != '0) &&
                           (32'(in_size) <= 32'(MEM_CELLS));
    assign accept        = s_tvalid && s_tready;

    // The cell memory: cleared after reset, scanned, then written with the owner.
    cba_mem #(
        .DEPTH  (MEM_CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (OWNER_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (addr_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_reg),
        .rd_data (mem_rd_data)
    );

    // The run tracker sees one cell per cycle, in the cycle after that cell's read address.
    cba_scan #(
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .cell_free (mem_rd_data == '0),
        .cell_addr (pipe_addr_reg),
        .req_size  (req_size_reg),
        .found     (scan_found),
        .pick_base (scan_base)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = in_ok ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = scan_found ? ST_WRITE : ST_DONE;
            end
            ST_WRITE: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs and datapath next values.
    always_comb begin
        s_tready       = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_data    = owner_reg;
        mem_rd_en      = 1'b0;
        out_load       = 1'b0;
        scan_ctl       = '{start: 1'b0, step: 1'b0, last: pipe_last_reg,
                           best: fit_mode_reg};
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        req_size_next  = req_size_reg;
        owner_next     = owner_reg;
        grant_next     = grant_reg;
        pipe_vld_next  = 1'b0;

        scan_ctl.step  = pipe_vld_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '0;
                addr_next   = (addr_reg == LAST_ADDR) ? '0 : addr_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    scan_ctl.start = 1'b1;
                    addr_next      = '0;
                    req_size_next  = in_size;
                    owner_next     = in_owner;
                    grant_next     = 1'b0;
                end
            end
            ST_SCAN: begin
                mem_rd_en     = 1'b1;
                pipe_vld_next = 1'b1;
                addr_next     = (addr_reg == LAST_ADDR) ? '0 : addr_reg + ADDR_W'(1);
            end
            ST_TAIL: begin
                // The last cell is consumed by the tracker in this cycle.
            end
            ST_DECIDE: begin
                grant_next = scan_found;
                addr_next  = scan_base;
                cnt_next   = CNT_W'(req_size_reg);
            end
            ST_WRITE: begin
                mem_wr_en = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            ST_DONE: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            pipe_vld_reg <= 1'b0;
            fit_mode_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            pipe_vld_reg <= pipe_vld_next;
            if (cfg_wr_en) begin
                fit_mode_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // The picked base is zero-extended into a 32-bit word before the result field
    // is cut out, so small memories still yield a full-width base address.
    assign base_wide = 32'(scan_base);

    // Payload registers.
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        req_size_reg  <= req_size_next;
        owner_reg     <= owner_next;
        grant_reg     <= grant_next;
        pipe_addr_reg <= addr_reg;
        pipe_last_reg <= (addr_reg == LAST_ADDR);
        if (out_load) begin
            m_grant_reg <= grant_reg;
            m_base_reg  <= grant_reg ? base_wide[BASE_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_grant_reg;
    assign m_tdata  = {{(16 - BASE_W){1'b0}}, m_base_reg};

    // A refused request always reports base address zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("refused request carries a nonzero base address");

    // Allocation writes never run past the last cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> (32'(addr_reg) < 32'(MEM_CELLS)))
        else $error("allocation write beyond the end of memory");

    // The write counter never underflows while filling a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> (cnt_reg != '0))
        else $error("allocation write with no cells left to fill");

    // Writing starts only after the scan found a fitting run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == ST_DECIDE && state_reg == ST_WRITE) |-> grant_reg)
        else $error("allocation started without a fitting run");

endmodule

// ===== verif/contiguous_block_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator_tb: self-checking bench for the cell allocator
// Streams allocation requests into the block and compares every result with
// a behavioral copy of the cell map. It covers both fit modes, the refusals,
// and filling memory up to its last cell, with random gaps on both streams.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_tb;
    import cba_pkg::*;

    localparam int MEM_CELLS  = 1024;
    localparam int OWNER_BITS = 10;
    // The slowest legal request scans all of memory and then writes all of it.
    // Add the sender gap and the receiver stall, then take that several times.
    localparam int STALL_LIMIT = 8 * (2 * MEM_CELLS + 64);

    // One request waiting to be sent, with the idle cycles that precede it.
    typedef struct {
        logic [SIZE_W-1:0]  size;
        logic [OWNER_W-1:0] owner;
        int                 gap;
    } alloc_req_t;

    // What the block must answer for one request.
    typedef struct packed {
        logic              granted;
        logic [BASE_W-1:0] base;
    } alloc_result_t;

    // Every input starts at a known value, before the first clock edge.
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;   // [10:0] request_size, [20:11] owner_id
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;            // [9:0] base_address
    logic        m_tuser;            // granted

    // Behavioral copy of the block's state.
    logic [OWNER_W-1:0] owner_map [MEM_CELLS];
    logic               best_fit = 1'b0;

    alloc_req_t    pending_requests [$];
    alloc_result_t expected_grants  [$];

    alloc_req_t    next_req;
    alloc_result_t want;
    int            gap_count;
    int            stall_left;
    int            results_seen;
    int            idle_cycles;
    int            error_count;
    int            requests_sent;
    int            grants_predicted;
    int            fit_settings;
    int            free_tail;   // free cells at the top of memory, as the stimulus sees it

    contiguous_block_allocator #(
        .MEM_CELLS  (MEM_CELLS),
        .OWNER_BITS (OWNER_BITS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Work out the answer to one accepted request and update the cell map.
    // Free cells form maximal runs; first fit stops at the first run that is
    // long enough, best fit keeps the shortest such run, the earliest on a tie.
    // A zero size, a zero owner or a size past memory is refused outright.
    function automatic void predict_allocation(input logic [SIZE_W-1:0]  size,
                                               input logic [OWNER_W-1:0] owner);
        alloc_result_t res;
        int            pos;
        int            start;
        int            run_len;
        int            pick_base;
        int            pick_len;
        logic          found;
        res       = '0;
        found     = 1'b0;
        pick_base = 0;
        pick_len  = 0;
        pos       = 0;
        if (size != 0 && owner != 0 && int'(size) <= MEM_CELLS) begin
            while (pos < MEM_CELLS && !(found && !best_fit)) begin
                if (owner_map[pos] != '0) begin
                    pos++;
                end else begin
                    start = pos;
                    while (pos < MEM_CELLS && owner_map[pos] == '0)
                        pos++;
                    run_len = pos - start;
                    if (run_len >= int'(size) && (!found || run_len < pick_len)) begin
                        found     = 1'b1;
                        pick_base = start;
                        pick_len  = run_len;
                    end
                end
            end
            if (found) begin
                for (int k = 0; k < int'(size); k++)
                    owner_map[pick_base + k] = owner;
                res.granted = 1'b1;
                res.base    = pick_base[BASE_W-1:0];
                grants_predicted++;
            end
        end
        expected_grants.push_back(res);
    endfunction

    // Queue one request. Every third stretch of two dozen requests goes out
    // back to back; elsewhere each request waits a random number of cycles.
    // The free-tail count lets the stimulus aim sizes at the end of memory.
    task automatic queue_request(input int size, input int owner);
        alloc_req_t req;
        req.size  = size[SIZE_W-1:0];
        req.owner = owner[OWNER_W-1:0];
        req.gap   = ((pending_requests.size() / 24) % 3 == 1) ? 0 : $urandom_range(0, 10);
        if (size > 0 && size <= free_tail && owner[OWNER_W-1:0] != 0)
            free_tail -= size;
        pending_requests.push_back(req);
    endtask

    // Mostly well-formed requests of a few cells, now and then a larger one,
    // plus refusals: zero size, zero owner, past memory, and one cell more
    // than is left, which forces a full scan that finds nothing.
    task automatic queue_random_phase(input int count);
        int pick;
        int owner;
        for (int k = 0; k < count; k++) begin
            pick  = $urandom_range(0, 19);
            owner = $urandom_range(1, (1 << OWNER_W) - 1);
            case (pick)
                0: queue_request(0, owner);
                1: queue_request($urandom_range(1, 64), 0);
                2: queue_request($urandom_range(MEM_CELLS + 1, (1 << SIZE_W) - 1), owner);
                3: queue_request(free_tail + 1, owner);
                4: queue_request($urandom_range(8, 32), owner);
                default: queue_request($urandom_range(1, 3), owner);
            endcase
        end
    endtask

    // Wait until every queued request is sent and every result is back.
    // Sampling at the falling edge keeps this clear of the clocked blocks.
    task automatic drain_results();
        do
            @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_grants.size() != 0);
    endtask

    // Write fit_mode while the block is idle, then resume at a falling edge
    // so that the next requests are queued away from the clock edge.
    task automatic write_fit_mode(input logic mode);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        best_fit     = mode;
        fit_settings++;
        @(negedge aclk);
    endtask

    // Request driver: presents the oldest queued request once its gap has
    // elapsed and predicts the answer at the edge where it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            gap_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_allocation(s_tdata[SIZE_W-1:0], s_tdata[SIZE_W +: OWNER_W]);
                requests_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (gap_count < pending_requests[0].gap) begin
                    gap_count <= gap_count + 1;
                    s_tvalid  <= 1'b0;
                end else begin
                    next_req  = pending_requests.pop_front();
                    gap_count <= 0;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {3'b000, next_req.owner, next_req.size};
                end
            end
        end
    end

    // Result monitor: checks each accepted result against the oldest
    // expectation. After each result the ready line may drop, and it comes
    // back only after the next result has waited its drawn number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_grants.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: granted=%0d base=%0d",
                                 m_tuser, m_tdata[BASE_W-1:0]);
                end else begin
                    want = expected_grants.pop_front();
                    if (m_tuser !== want.granted || m_tdata[BASE_W-1:0] !== want.base) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("result %0d: expected granted=%0d base=%0d, got granted=%0d base=%0d",
                                     results_seen, want.granted, want.base,
                                     m_tuser, m_tdata[BASE_W-1:0]);
                    end
                end
                if ((results_seen / 16) % 3 == 2) begin
                    m_tready   <= 1'b1;
                    stall_left <= 0;
                end else begin
                    stall_left <= $urandom_range(0, 10);
                    m_tready   <= 1'b0;
                end
            end else if (!m_tready && m_tvalid) begin
                if (stall_left <= 1)
                    m_tready <= 1'b1;
                stall_left <= stall_left - 1;
            end
        end
    end

    // Watchdog: the run ends if no handshake happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("contiguous_block_allocator_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < MEM_CELLS; k++)
            owner_map[k] = '0;
        error_count      = 0;
        requests_sent    = 0;
        grants_predicted = 0;
        fit_settings     = 0;
        results_seen     = 0;
        idle_cycles      = 0;
        free_tail        = MEM_CELLS;

        // Reset is held once, at the start. The block then clears its map,
        // which the driver simply waits out on the ready line.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part in best fit: every refusal reason, owner and size
        // extremes, and requests that are too large for what is left.
        write_fit_mode(1'b1);
        queue_request(0, 5);                      // zero size
        queue_request(4, 0);                      // zero owner
        queue_request(0, 0);
        queue_request((1 << SIZE_W) - 1, 7);      // every size bit set
        queue_request(MEM_CELLS + 1, 7);          // one past memory
        queue_request(1, 1);
        queue_request(1, (1 << OWNER_W) - 1);
        queue_request(3, 'h2AA);
        queue_request(3, 'h155);
        queue_request(MEM_CELLS, 9);              // whole memory, no longer free
        queue_request(free_tail + 1, 11);         // one more than the free run
        queue_request(16, (1 << OWNER_W) - 1);
        queue_request(MEM_CELLS, 0);
        queue_request(2, 'h200);
        drain_results();

        // Random phases alternate the fit mode. Each phase boundary makes
        // the sender hold off until every result is back.
        write_fit_mode(1'b0);
        queue_random_phase(85);
        drain_results();

        write_fit_mode(1'b1);
        queue_random_phase(85);
        drain_results();

        // Last phase fills memory to its final cell: a request one cell too
        // large is refused, the exact remainder is granted, and after that
        // even a single cell is refused.
        write_fit_mode(1'b0);
        queue_random_phase(80);
        queue_request(free_tail + 1, 'h155);
        if (free_tail > 0)
            queue_request(free_tail, (1 << OWNER_W) - 1);
        queue_request(1, 'h2AA);
        queue_request(MEM_CELLS, 3);
        queue_request(2, 1);
        drain_results();

        // Give a stray result time to show up before the verdict.
        repeat (64) @(posedge aclk);

        $display("%0d requests sent, %0d granted and %0d refused, over %0d fit-mode writes",
                 requests_sent, grants_predicted, requests_sent - grants_predicted,
                 fit_settings);
        $display("first fit and best fit both used; %0d cells were left free at the end",
                 free_tail);
        if (error_count == 0)
            $display("contiguous_block_allocator_tb: done, clean");
        else
            $display("contiguous_block_allocator_tb: done, errors");
        $finish;
    end

endmodule
